// ===== rtl/uart_fifo_register_block_defines.svh =====
// Assertion macros shared by the UART register block RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef UART_FIFO_REGISTER_BLOCK_DEFINES_SVH
`define UART_FIFO_REGISTER_BLOCK_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define UFRB_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define UFRB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/ufrb_pkg.sv =====
// Package of the UART register block: default sizes, register indexes, opcodes, states.
// Depends on nothing.
`default_nettype none
package ufrb_pkg;
   localparam int TxDepthDefault  = 128;
   localparam int RxDepthDefault  = 128;
   localparam int IrqCountDefault = 8;

   typedef enum logic [1:0] {
      OP_READ  = 2'd0,
      OP_WRITE = 2'd1,
      OP_LINE  = 2'd2,
      OP_SLOT  = 2'd3
   } opcode_type;

   localparam logic [3:0] REG_IRQ_PEND    = 4'd0;
   localparam logic [3:0] REG_IRQ_MASK    = 4'd1;
   localparam logic [3:0] REG_INTR_TEST   = 4'd2;
   localparam logic [3:0] REG_CTRL        = 4'd4;
   localparam logic [3:0] REG_STATUS      = 4'd5;
   localparam logic [3:0] REG_RDATA       = 4'd6;
   localparam logic [3:0] REG_WDATA       = 4'd7;
   localparam logic [3:0] REG_QUEUE_CTRL  = 4'd8;
   localparam logic [3:0] REG_FIFO_STATUS = 4'd9;
   localparam logic [3:0] REG_OVRD        = 4'd10;
   localparam logic [3:0] REG_TIMEOUT     = 4'd12;

   localparam logic [31:0] CTRL_KEEP    = 32'hffff03f7;
   localparam logic [31:0] TIMEOUT_KEEP = 32'h80ffffff;
   localparam int IRQ_TXWM    = 0;
   localparam int IRQ_RXWM    = 1;
   localparam int IRQ_TXEMPTY = 2;
   localparam int IRQ_RXOVF   = 3;
   localparam int CTRL_TX     = 0;
   localparam int CTRL_RX     = 1;
   localparam int CTRL_SLPBK  = 4;

   typedef enum logic [0:0] {
      ST_ACCEPT = 1'b0,
      ST_FINISH = 1'b1
   } state_type;

   // Watermark levels from the 3-bit select codes.
   function automatic logic [7:0] tx_level_f(input logic [2:0] sel);
      tx_level_f = (sel == 3'd7) ? 8'd64 : (8'd1 << sel);
   endfunction

   function automatic logic [7:0] rx_level_f(input logic [2:0] sel);
      rx_level_f = (sel == 3'd7) ? 8'd126 : (8'd1 << sel);
   endfunction
endpackage
`default_nettype wire

// ===== rtl/ufrb_if.sv =====
// Valid/ready channel interfaces for the UART register block.
// Depends on nothing.
`default_nettype none
interface ufrb_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [3:0]  reg_index;
   logic [31:0] write_data;
   logic [7:0]  line_in_byte;
   modport source (output valid, opcode, reg_index, write_data, line_in_byte,
                   input ready);
   modport sink   (input valid, opcode, reg_index, write_data, line_in_byte,
                   output ready);
endinterface

interface ufrb_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] read_data;
   logic [7:0]  irq_lines;
   logic        line_out_valid;
   logic [7:0]  line_out_byte;
   logic        rx_can_accept;
   modport source (output valid, read_data, irq_lines, line_out_valid, line_out_byte,
                   rx_can_accept, input ready);
   modport sink   (input valid, read_data, irq_lines, line_out_valid, line_out_byte,
                   rx_can_accept, output ready);
endinterface
`default_nettype wire

// ===== rtl/uart_fifo_register_block.sv =====
// Top level of the UART register block with transmit and receive queues.
// Depends on ufrb_pkg, ufrb_if, ufrb_fifo_mem and the assertion macro header.
//
//   channel | direction | contents
//   req     | in        | opcode, reg_index, write_data, line_in_byte
//   rsp     | out       | read_data, irq_lines, line_out_valid, line_out_byte, rx_can_accept
//
// In the accept state both queue memories are addressed at their heads, and in
// the finish state the registered read data is used and state is updated.
// The registered read port of the queue memories is why the finish state exists.
// The result sits in an output register; a new item may be accepted while it waits,
// and that item's finish state then stalls until the register frees.
// Reset is synchronous.
`default_nettype none
`include "uart_fifo_register_block_defines.svh"
module uart_fifo_register_block #(
   parameter int TX_DEPTH  = ufrb_pkg::TxDepthDefault,
   parameter int RX_DEPTH  = ufrb_pkg::RxDepthDefault,
   parameter int IRQ_COUNT = ufrb_pkg::IrqCountDefault
) (
   input wire logic clock,
   input wire logic reset,
   ufrb_req_if.sink   req,
   ufrb_rsp_if.source rsp
);
   import ufrb_pkg::*;

   localparam int TA = $clog2(TX_DEPTH);
   localparam int RA = $clog2(RX_DEPTH);
   localparam int TF = $clog2(TX_DEPTH + 1);
   localparam int RF = $clog2(RX_DEPTH + 1);

   state_type state_ff, state_in;

   // Held item.
   logic [1:0]  op_ff;
   logic [3:0]  idx_ff;
   logic [31:0] wd_ff;
   logic [7:0]  lb_ff;

   logic [TA-1:0] tx_head_ff, tx_head_in;
   logic [TF-1:0] tx_fill_ff, tx_fill_in;
   logic [RA-1:0] rx_head_ff, rx_head_in;
   logic [RF-1:0] rx_fill_ff, rx_fill_in;
   logic [IRQ_COUNT-1:0] pend_ff, pend_in, ien_ff, ien_in;
   logic [31:0] ctrl_ff, ctrl_in, tmo_ff, tmo_in;
   logic [5:0]  wsel_ff, wsel_in;
   logic [1:0]  ovrd_ff, ovrd_in;
   logic [7:0]  armed_ff, armed_in;

   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_rd_ff, out_rd_in;
   logic [7:0]  out_irq_ff, out_irq_in, out_ob_ff, out_ob_in;
   logic        out_ov_ff, out_ov_in, out_rxa_ff, out_rxa_in;

   logic          tx_we, rx_we;
   logic [TA-1:0] tx_wa;
   logic [RA-1:0] rx_wa;
   logic [7:0]    tx_wd, rx_wd, tx_rd, rx_rd;

   ufrb_fifo_mem #(.DEPTH(TX_DEPTH)) u_tx_mem (
      .clock, .wr_en(tx_we), .wr_addr(tx_wa), .wr_data(tx_wd),
      .rd_addr(tx_head_ff), .rd_data(tx_rd));
   ufrb_fifo_mem #(.DEPTH(RX_DEPTH)) u_rx_mem (
      .clock, .wr_en(rx_we), .wr_addr(rx_wa), .wr_data(rx_wd),
      .rd_addr(rx_head_ff), .rd_data(rx_rd));

   logic out_free;
   assign out_free  = !out_valid_ff || rsp.ready;
   assign req.ready = (state_ff == ST_ACCEPT) && !reset;

   assign rsp.valid          = out_valid_ff;
   assign rsp.read_data      = out_rd_ff;
   assign rsp.irq_lines      = out_irq_ff;
   assign rsp.line_out_valid = out_ov_ff;
   assign rsp.line_out_byte  = out_ob_ff;
   assign rsp.rx_can_accept  = out_rxa_ff;

   // Receive-queue push, shared by line bytes and loopback. Heads stay put during
   // a push, so the write address is head plus fill wrapped once.
   function automatic logic [RA-1:0] rx_pos(input logic [RA-1:0] h,
                                            input logic [RF-1:0] f);
      logic [RA+1:0] s;
      s = {2'b00, h} + {1'b0, f};
      if (s >= (RA+2)'(RX_DEPTH)) s = s - (RA+2)'(RX_DEPTH);
      rx_pos = s[RA-1:0];
   endfunction

   function automatic logic [TA-1:0] tx_pos(input logic [TA-1:0] h,
                                            input logic [TF-1:0] f);
      logic [TA+1:0] s;
      s = {2'b00, h} + {1'b0, f};
      if (s >= (TA+2)'(TX_DEPTH)) s = s - (TA+2)'(TX_DEPTH);
      tx_pos = s[TA-1:0];
   endfunction

   always_comb begin
      logic       do_rx;
      logic [7:0] rx_byte;
      logic [7:0] lvl;
      logic [8:0] fill9;
      state_in   = state_ff;
      tx_head_in = tx_head_ff;  tx_fill_in = tx_fill_ff;
      rx_head_in = rx_head_ff;  rx_fill_in = rx_fill_ff;
      pend_in = pend_ff;  ien_in = ien_ff;  ctrl_in = ctrl_ff;  tmo_in = tmo_ff;
      wsel_in = wsel_ff;  ovrd_in = ovrd_ff;  armed_in = armed_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_rd_in = out_rd_ff;  out_irq_in = out_irq_ff;  out_ov_in = out_ov_ff;
      out_ob_in = out_ob_ff;  out_rxa_in = out_rxa_ff;
      tx_we = 1'b0;  tx_wa = tx_pos(tx_head_ff, tx_fill_ff);  tx_wd = wd_ff[7:0];
      rx_we = 1'b0;  rx_wa = rx_pos(rx_head_ff, rx_fill_ff);  rx_wd = lb_ff;
      do_rx = 1'b0;  rx_byte = lb_ff;  lvl = 8'd0;  fill9 = 9'd0;

      case (state_ff)
         ST_ACCEPT: begin
            if (req.valid) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in  = ST_ACCEPT;
               out_rd_in = 32'd0;  out_ov_in = 1'b0;  out_ob_in = 8'd0;
               case (opcode_type'(op_ff))
                  OP_READ: begin
                     case (idx_ff)
                        REG_IRQ_PEND:    out_rd_in = 32'(pend_ff);
                        REG_IRQ_MASK:    out_rd_in = 32'(ien_ff);
                        REG_CTRL:        out_rd_in = ctrl_ff;
                        REG_STATUS: begin
                           out_rd_in[4] = 1'b1;
                           if (rx_fill_ff == '0) out_rd_in[5] = 1'b1;
                           else if (rx_fill_ff >= RF'(RX_DEPTH)) out_rd_in[1] = 1'b1;
                           if (tx_fill_ff == '0) out_rd_in[3:2] = 2'b11;
                           else if (tx_fill_ff >= TF'(TX_DEPTH)) out_rd_in[0] = 1'b1;
                           if (!ctrl_ff[CTRL_TX]) out_rd_in[3] = 1'b1;
                        end
                        REG_RDATA: begin
                           if (ctrl_ff[CTRL_RX] && rx_fill_ff != '0) begin
                              out_rd_in  = {24'd0, rx_rd};
                              rx_head_in = (rx_head_ff == RA'(RX_DEPTH - 1)) ?
                                           '0 : rx_head_ff + 1'b1;
                              rx_fill_in = rx_fill_ff - 1'b1;
                           end
                        end
                        REG_QUEUE_CTRL:  out_rd_in = {24'd0, wsel_ff, 2'b00};
                        REG_FIFO_STATUS: begin
                           fill9 = 9'(rx_fill_ff);
                           out_rd_in[23:16] = fill9[7:0];
                           fill9 = 9'(tx_fill_ff);
                           out_rd_in[7:0] = fill9[7:0];
                        end
                        REG_OVRD:    out_rd_in = {30'd0, ovrd_ff};
                        REG_TIMEOUT: out_rd_in = tmo_ff;
                        default:     out_rd_in = 32'd0;
                     endcase
                  end
                  OP_WRITE: begin
                     case (idx_ff)
                        REG_IRQ_PEND:    pend_in = pend_ff & ~wd_ff[IRQ_COUNT-1:0];
                        REG_IRQ_MASK:    ien_in  = wd_ff[IRQ_COUNT-1:0];
                        REG_INTR_TEST:   pend_in = pend_ff | wd_ff[IRQ_COUNT-1:0];
                        REG_CTRL:        ctrl_in = wd_ff & CTRL_KEEP;
                        REG_WDATA: begin
                           if (tx_fill_ff < TF'(TX_DEPTH)) begin
                              tx_we      = 1'b1;
                              tx_fill_in = tx_fill_ff + 1'b1;
                              lvl        = tx_level_f(wsel_ff[5:3]);
                              fill9      = 9'(tx_fill_in);
                              armed_in   = (fill9 < {1'b0, lvl}) ? 8'd0 : lvl;
                           end
                        end
                        REG_QUEUE_CTRL: begin
                           wsel_in = wd_ff[7:2];
                           if (wd_ff[0]) begin
                              rx_head_in = '0;  rx_fill_in = '0;
                              pend_in[IRQ_RXWM]  = 1'b0;
                              pend_in[IRQ_RXOVF] = 1'b0;
                           end
                           if (wd_ff[1]) begin
                              tx_head_in = '0;  tx_fill_in = '0;
                              pend_in[IRQ_TXEMPTY] = 1'b1;
                              if (armed_ff != 8'd0) begin
                                 pend_in[IRQ_TXWM] = 1'b1;
                                 armed_in = 8'd0;
                              end
                           end
                        end
                        REG_OVRD:    ovrd_in = {wd_ff[1], 1'b0};
                        REG_TIMEOUT: tmo_in  = wd_ff & TIMEOUT_KEEP;
                        default: ;
                     endcase
                  end
                  OP_LINE: begin
                     do_rx = ctrl_ff[CTRL_RX];
                  end
                  OP_SLOT: begin
                     if (ctrl_ff[CTRL_TX] && tx_fill_ff != '0) begin
                        tx_head_in = (tx_head_ff == TA'(TX_DEPTH - 1)) ?
                                     '0 : tx_head_ff + 1'b1;
                        tx_fill_in = tx_fill_ff - 1'b1;
                        if (ctrl_ff[CTRL_SLPBK]) begin
                           do_rx = 1'b1;  rx_byte = tx_rd;
                        end else begin
                           out_ov_in = 1'b1;  out_ob_in = tx_rd;
                        end
                        if (tx_fill_in == '0) pend_in[IRQ_TXEMPTY] = 1'b1;
                        fill9 = 9'(tx_fill_in);
                        if (armed_ff != 8'd0 && fill9 < {1'b0, armed_ff}) begin
                           pend_in[IRQ_TXWM] = 1'b1;
                           armed_in = 8'd0;
                        end
                     end
                  end
                  default: ;
               endcase

               if (do_rx) begin
                  rx_wd = rx_byte;
                  if (rx_fill_ff >= RF'(RX_DEPTH)) begin
                     pend_in[IRQ_RXOVF] = 1'b1;
                  end else begin
                     rx_we      = 1'b1;
                     rx_fill_in = rx_fill_ff + 1'b1;
                  end
                  fill9 = 9'(rx_fill_in);
                  if (fill9 >= {1'b0, rx_level_f(wsel_ff[2:0])}) pend_in[IRQ_RXWM] = 1'b1;
               end

               out_valid_in = 1'b1;
               out_irq_in   = 8'(pend_in & ien_in);
               out_rxa_in   = ctrl_in[CTRL_RX] && (rx_fill_in < RF'(RX_DEPTH));
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
         tx_head_ff <= '0;  tx_fill_ff <= '0;  rx_head_ff <= '0;  rx_fill_ff <= '0;
         pend_ff <= IRQ_COUNT'(1 << IRQ_TXEMPTY);
         ien_ff <= '0;  ctrl_ff <= '0;  tmo_ff <= '0;  wsel_ff <= '0;
         ovrd_ff <= '0;  armed_ff <= '0;  out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         tx_head_ff <= tx_head_in;  tx_fill_ff <= tx_fill_in;
         rx_head_ff <= rx_head_in;  rx_fill_ff <= rx_fill_in;
         pend_ff <= pend_in;  ien_ff <= ien_in;  ctrl_ff <= ctrl_in;  tmo_ff <= tmo_in;
         wsel_ff <= wsel_in;  ovrd_ff <= ovrd_in;  armed_ff <= armed_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         op_ff <= req.opcode;  idx_ff <= req.reg_index;
         wd_ff <= req.write_data;  lb_ff <= req.line_in_byte;
      end
      out_rd_ff <= out_rd_in;  out_irq_ff <= out_irq_in;  out_ov_ff <= out_ov_in;
      out_ob_ff <= out_ob_in;  out_rxa_ff <= out_rxa_in;
   end

   `UFRB_ASSERT_IMPL(a_tx_fill_bound, clock, reset, 1'b1, tx_fill_ff <= TF'(TX_DEPTH))
   `UFRB_ASSERT_IMPL(a_rx_fill_bound, clock, reset, 1'b1, rx_fill_ff <= RF'(RX_DEPTH))
   `UFRB_ASSERT_NEXT(a_accept_to_finish, clock, reset, req.valid && req.ready,
                     state_ff == ST_FINISH)
   `UFRB_ASSERT_IMPL(a_line_byte_zero, clock, reset, rsp.valid && !rsp.line_out_valid,
                     rsp.line_out_byte == 8'd0)
endmodule
`default_nettype wire

// ===== rtl/ufrb_fifo_mem.sv =====
// Byte storage of one queue: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module ufrb_fifo_mem #(
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [7:0]               wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [7:0]               rd_data
);
   logic [7:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire
